[rtl/ffa_pkg.sv]
package ffa_pkg;

  localparam int ADDR_BITS        = 32;
  localparam int HEADER_BYTES     = 16;
  localparam int MAX_SEGMENTS_DEF = 64;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_BADFREE = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_NRD,
    ST_NCHK,
    ST_PLAN,
    ST_MVRD,
    ST_MVWR,
    ST_WR0,
    ST_WR1,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        used;
    logic [31:0] start;
    logic [31:0] size;
  } seg_entry_t;

  // payload address of a segment, wrapped to ADDR_BITS
  function automatic logic [33:0] payload_of(logic [31:0] base, logic [31:0] start);
    logic [33:0] sum;
    logic [33:0] msk;
    sum = {2'b0, base} + {2'b0, start} + 34'(HEADER_BYTES);
    msk = (ADDR_BITS >= 34) ? '1 : 34'((64'd1 << ADDR_BITS) - 64'd1);
    return sum & msk;
  endfunction

  function automatic logic [33:0] addr_wrap(logic [31:0] a);
    logic [33:0] msk;
    msk = (ADDR_BITS >= 34) ? '1 : 34'((64'd1 << ADDR_BITS) - 64'd1);
    return {2'b0, a} & msk;
  endfunction

endpackage

[rtl/first_fit_heap_allocator_core.sv]
// Address-ordered first-fit heap allocator. Each request (allocate or free)
// produces exactly one result. Segments live in a table memory with one
// write port and one registered read port; a small sequencer walks it one
// entry at a time, reading and then checking each entry until the first match
// (or the whole table), then reads the successor, plans, shifts entries one
// by one when a split inserts or a free coalesces, writes the table and
// loads the result register. Scanned and shifted entries together never
// exceed the live count. The request side stalls while a request is in
// work; a finished result waits in the output register and a new request
// can be taken meanwhile. No clearing pass is needed after reset: only the
// first segment_count entries are ever read. Configuration registers are
// always writable (cfg_ready high) and should only change while the block
// is idle.
module first_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [31:0]         in_alloc_size,
  input  logic [31:0]         in_free_address,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [31:0]         out_payload_address,
  // config writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import ffa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  state_t      state_r, state_nxt;
  logic        req_free_r, req_free_nxt;
  logic [32:0] need_r, need_nxt;         // rounded size, can reach 2^32
  logic [31:0] addr_r, addr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  seg_entry_t  cur_r, cur_nxt;
  seg_entry_t  prev_r, prev_nxt;
  seg_entry_t  nxt_r, nxt_nxt;
  logic        have_nxt_r, have_nxt_nxt;
  logic        found_r, found_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] heap_end_r, heap_end_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] limit_r, limit_nxt;
  // pending table writes after the shift
  logic        w0_en_r, w0_en_nxt;
  logic [IW-1:0] w0_idx_r, w0_idx_nxt;
  seg_entry_t  w0_r, w0_nxt;
  logic        w1_en_r, w1_en_nxt;
  logic [IW-1:0] w1_idx_r, w1_idx_nxt;
  seg_entry_t  w1_r, w1_nxt;
  // shift engine
  logic [CW-1:0] mv_src_r, mv_src_nxt;
  logic [CW-1:0] mv_stop_r, mv_stop_nxt;
  logic        mv_up_r, mv_up_nxt;
  logic [1:0]  mv_k_r, mv_k_nxt;
  // result
  status_t     res_status_r, res_status_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;

  // table port
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  seg_entry_t  mem_wdata;
  logic [IW-1:0] mem_raddr;
  seg_entry_t  mem_rdata;

  ffa_seg_mem #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_stall            = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;

  // plan-stage helpers
  logic [CW-1:0] idx_p1;
  logic          hit_alloc, hit_free, split_ok, grow_oom, prev_free, nxt_free;
  logic [31:0]   new_start, rest, start_j, base_sz;
  logic [33:0]   pay;
  logic [1:0]    k;
  logic [CW-1:0] rm_at, j_idx, mv_dst;

  always_comb begin
    idx_p1    = idx_r + CW'(1);
    hit_alloc = !mem_rdata.used && ({1'b0, mem_rdata.size} >= need_r);
    hit_free  = mem_rdata.used &&
                (payload_of(base_r, mem_rdata.start) == addr_wrap(addr_r));
    split_ok  = ({3'b0, cur_r.size} >= {2'b0, need_r} + 35'(HEADER_BYTES + 8)) &&
                (count_r < CW'(MAX_SEGMENTS));
    grow_oom  = (count_r >= CW'(MAX_SEGMENTS)) ||
                ({3'b0, heap_end_r} + 35'(HEADER_BYTES) + {2'b0, need_r} >
                 {3'b0, limit_r});
    new_start = cur_r.start + 32'(HEADER_BYTES) + need_r[31:0];
    rest      = cur_r.size - need_r[31:0] - 32'(HEADER_BYTES);
    prev_free = (idx_r != '0) && !prev_r.used;
    nxt_free  = have_nxt_r && !nxt_r.used;
    start_j   = prev_free ? prev_r.start : cur_r.start;
    base_sz   = prev_free ? (prev_r.size + 32'(HEADER_BYTES) + cur_r.size) : cur_r.size;
    j_idx     = prev_free ? (idx_r - CW'(1)) : idx_r;
    k         = {1'b0, prev_free} + {1'b0, nxt_free};
    rm_at     = prev_free ? idx_r : idx_p1;
    pay       = payload_of(base_r, found_r ? cur_r.start : heap_end_r);
    mv_dst    = mv_up_r ? (mv_src_r + CW'(1)) : (mv_src_r - CW'(mv_k_r));
  end

  always_comb begin
    state_nxt      = state_r;
    req_free_nxt   = req_free_r;
    need_nxt       = need_r;
    addr_nxt       = addr_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    nxt_nxt        = nxt_r;
    have_nxt_nxt   = have_nxt_r;
    found_nxt      = found_r;
    count_nxt      = count_r;
    heap_end_nxt   = heap_end_r;
    base_nxt       = base_r;
    limit_nxt      = limit_r;
    w0_en_nxt      = w0_en_r;
    w0_idx_nxt     = w0_idx_r;
    w0_nxt         = w0_r;
    w1_en_nxt      = w1_en_r;
    w1_idx_nxt     = w1_idx_r;
    w1_nxt         = w1_r;
    mv_src_nxt     = mv_src_r;
    mv_stop_nxt    = mv_stop_r;
    mv_up_nxt      = mv_up_r;
    mv_k_nxt       = mv_k_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    mem_we         = 1'b0;
    mem_waddr      = w0_idx_r;
    mem_wdata      = w0_r;
    mem_raddr      = idx_r[IW-1:0];

    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAP_BASE:  base_nxt  = cfg_data;
        REG_HEAP_LIMIT: limit_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_free_nxt = in_req_type;
          need_nxt     = ({1'b0, in_alloc_size} + 33'd7) & ~33'd7;
          addr_nxt     = in_free_address;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          have_nxt_nxt = 1'b0;
          w0_en_nxt    = 1'b0;
          w1_en_nxt    = 1'b0;
          state_nxt    = ST_SRD;
        end
      end
      ST_SRD: begin
        if (idx_r == count_r) begin
          state_nxt = ST_PLAN;
        end else begin
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (req_free_r ? hit_free : hit_alloc) begin
          cur_nxt   = mem_rdata;
          found_nxt = 1'b1;
          state_nxt = ST_NRD;
        end else begin
          prev_nxt  = mem_rdata;
          idx_nxt   = idx_p1;
          state_nxt = ST_SRD;
        end
      end
      ST_NRD: begin
        mem_raddr = idx_p1[IW-1:0];
        if (idx_p1 < count_r) begin
          state_nxt = ST_NCHK;
        end else begin
          have_nxt_nxt = 1'b0;
          state_nxt    = ST_PLAN;
        end
      end
      ST_NCHK: begin
        nxt_nxt      = mem_rdata;
        have_nxt_nxt = 1'b1;
        state_nxt    = ST_PLAN;
      end
      ST_PLAN: begin
        state_nxt      = ST_WR0;
        res_status_nxt = STAT_OK;
        res_addr_nxt   = '0;
        if (req_free_r == REQ_ALLOC) begin
          if (found_r) begin
            res_addr_nxt = pay[31:0];
            w0_en_nxt    = 1'b1;
            w0_idx_nxt   = idx_r[IW-1:0];
            if (split_ok) begin
              w0_nxt     = '{used: 1'b1, start: cur_r.start, size: need_r[31:0]};
              w1_en_nxt  = 1'b1;
              w1_idx_nxt = idx_p1[IW-1:0];
              if (nxt_free) begin
                // remainder absorbs the free successor in place
                w1_nxt = '{used: 1'b0, start: new_start,
                           size: rest + 32'(HEADER_BYTES) + nxt_r.size};
              end else begin
                w1_nxt    = '{used: 1'b0, start: new_start, size: rest};
                count_nxt = count_r + CW'(1);
                if (have_nxt_r) begin
                  mv_up_nxt   = 1'b1;
                  mv_k_nxt    = 2'd1;
                  mv_src_nxt  = count_r - CW'(1);
                  mv_stop_nxt = idx_p1;
                  state_nxt   = ST_MVRD;
                end
              end
            end else begin
              w0_nxt = '{used: 1'b1, start: cur_r.start, size: cur_r.size};
            end
          end else if (grow_oom) begin
            res_status_nxt = STAT_OOM;
            state_nxt      = ST_FIN;
          end else begin
            res_addr_nxt = pay[31:0];
            w0_en_nxt    = 1'b1;
            w0_idx_nxt   = count_r[IW-1:0];
            w0_nxt       = '{used: 1'b1, start: heap_end_r, size: need_r[31:0]};
            count_nxt    = count_r + CW'(1);
            heap_end_nxt = heap_end_r + 32'(HEADER_BYTES) + need_r[31:0];
          end
        end else begin
          if (!found_r) begin
            res_status_nxt = STAT_BADFREE;
            state_nxt      = ST_FIN;
          end else if (!have_nxt_r) begin
            // released segment ends up last: trim the heap
            heap_end_nxt = start_j;
            count_nxt    = count_r - (prev_free ? CW'(2) : CW'(1));
            state_nxt    = ST_FIN;
          end else begin
            w0_en_nxt  = 1'b1;
            w0_idx_nxt = j_idx[IW-1:0];
            w0_nxt     = '{used: 1'b0, start: start_j,
                           size: base_sz + (nxt_free ?
                                 (32'(HEADER_BYTES) + nxt_r.size) : 32'd0)};
            count_nxt  = count_r - CW'(k);
            if ((k != 2'd0) && (rm_at + CW'(k) < count_r)) begin
              mv_up_nxt   = 1'b0;
              mv_k_nxt    = k;
              mv_src_nxt  = rm_at + CW'(k);
              mv_stop_nxt = count_r - CW'(1);
              state_nxt   = ST_MVRD;
            end
          end
        end
      end
      ST_MVRD: begin
        mem_raddr = mv_src_r[IW-1:0];
        state_nxt = ST_MVWR;
      end
      ST_MVWR: begin
        mem_we    = 1'b1;
        mem_waddr = mv_dst[IW-1:0];
        mem_wdata = mem_rdata;
        if (mv_src_r == mv_stop_r) begin
          state_nxt = ST_WR0;
        end else begin
          mv_src_nxt = mv_up_r ? (mv_src_r - CW'(1)) : (mv_src_r + CW'(1));
          state_nxt  = ST_MVRD;
        end
      end
      ST_WR0: begin
        mem_we    = w0_en_r;
        mem_waddr = w0_idx_r;
        mem_wdata = w0_r;
        state_nxt = ST_WR1;
      end
      ST_WR1: begin
        mem_we    = w1_en_r;
        mem_waddr = w1_idx_r;
        mem_wdata = w1_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      heap_end_r  <= '0;
      base_r      <= '0;
      limit_r     <= 32'd65536;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      heap_end_r  <= heap_end_nxt;
      base_r      <= base_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_free_r   <= req_free_nxt;
    need_r       <= need_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    nxt_r        <= nxt_nxt;
    have_nxt_r   <= have_nxt_nxt;
    found_r      <= found_nxt;
    w0_en_r      <= w0_en_nxt;
    w0_idx_r     <= w0_idx_nxt;
    w0_r         <= w0_nxt;
    w1_en_r      <= w1_en_nxt;
    w1_idx_r     <= w1_idx_nxt;
    w1_r         <= w1_nxt;
    mv_src_r     <= mv_src_nxt;
    mv_stop_r    <= mv_stop_nxt;
    mv_up_r      <= mv_up_nxt;
    mv_k_r       <= mv_k_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_OK) |-> out_addr_r == '0)
    else $error("failed request carries an address");

  a_free_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLAN) && req_free_r |=> heap_end_r <= $past(heap_end_r))
    else $error("free request grew the heap");

  a_plan_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && !out_stall |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished request not delivered");
`endif

endmodule

[rtl/ffa_seg_mem.sv]
module ffa_seg_mem #(
  parameter int DEPTH = ffa_pkg::MAX_SEGMENTS_DEF,
  parameter int IW    = $clog2(ffa_pkg::MAX_SEGMENTS_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  ffa_pkg::seg_entry_t wr_data,
  input  logic [IW-1:0]       rd_addr,
  output ffa_pkg::seg_entry_t rd_data
);
  import ffa_pkg::*;

  seg_entry_t mem [DEPTH];
  seg_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
